/* sv/bshph_pkg.sv */
// Package: constants, register codes and the bar entry type for the bar smoother core.
`default_nettype none

package bshph_pkg;

  localparam int BARS_DEFAULT = 32;

  localparam int IDX_W   = 5;
  localparam int LEVEL_W = 16;
  localparam int HOLD_W  = 8;
  localparam int CFG_W   = 16;

  localparam logic [15:0] ATTACK_RESET  = 16'd39322;
  localparam logic [15:0] RELEASE_RESET = 16'd9830;
  localparam logic [7:0]  HOLD_RESET    = 8'd30;
  localparam logic [15:0] FALL_RESET    = 16'd1311;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_HOLD    = 2'd2,
    REG_FALL    = 2'd3
  } cfg_reg_t;

  // one stored bar entry
  typedef struct packed {
    logic [LEVEL_W-1:0] sm;
    logic [LEVEL_W-1:0] cap;
    logic [HOLD_W-1:0]  hold;
  } entry_t;

endpackage

`default_nettype wire

/* sv/bar_smoother_with_peak_hold_core.sv */
// Top level: per-bar attack/release smoother with peak cap hold and fall.
//
// Usage:
//   Item channel (item_valid/item_stall) carries bar_index and level. A word is
//   taken at a clock edge with item_valid high and item_stall low.
//   Result channel (result_valid/result_stall) returns bar_number, smoothed_level,
//   peak_cap and hold_left, one result word per item, in order.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes attack weight,
//   release weight, hold length and fall step; write only while the core is idle.
// Pipeline:
//   Read stage, weight/difference stage, multiply stage; the cap/hold update feeds
//   the output register, which presents the result word.
//   One item per cycle is sustained while the receiver does not stall and no item
//   waits on its bar. An item for a bar that is still in the three compute stages
//   waits until that bar's earlier word is written back; the bar state memory has a single read and write port.
// Reset clears the control state, the registers to their defaults and one valid
//   flag per bar, so all bars read as zero; no clearing pass is needed.
// When the receiver stalls, the output register holds and the stages behind it
//   keep filling; item_stall rises once the pipeline is full.
`default_nettype none

module bar_smoother_with_peak_hold_core
  import bshph_pkg::*;
#(
  parameter int BARS = BARS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output      logic                item_stall,
  input  wire logic [IDX_W-1:0]    bar_index,
  input  wire logic [LEVEL_W-1:0]  level,
  output      logic                result_valid,
  input  wire logic                result_stall,
  output      logic [IDX_W-1:0]    bar_number,
  output      logic [LEVEL_W-1:0]  smoothed_level,
  output      logic [LEVEL_W-1:0]  peak_cap,
  output      logic [HOLD_W-1:0]   hold_left,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  localparam int AW = (BARS > 1) ? $clog2(BARS) : 1;

  // config registers
  logic [15:0] attack_weight;
  logic [15:0] release_weight;
  logic [7:0]  hold_length;
  logic [15:0] fall_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_weight  <= ATTACK_RESET;
      release_weight <= RELEASE_RESET;
      hold_length    <= HOLD_RESET;
      fall_step      <= FALL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK:  attack_weight  <= cfg_data;
        REG_RELEASE: release_weight <= cfg_data;
        REG_HOLD:    hold_length    <= cfg_data[7:0];
        REG_FALL:    fall_step      <= cfg_data;
        default:     ;
      endcase
    end
  end

  // bar state memory and per-bar valid flags
  entry_t           mem [BARS];
  logic [BARS-1:0]  known;

  // stage 1: memory read data
  logic                s1_valid;
  logic                s1_ok;
  logic [IDX_W-1:0]    s1_bar;
  logic [LEVEL_W-1:0]  s1_level;
  entry_t              rd_word;
  logic                rd_known;

  // stage 2: weight and signed difference
  logic                s2_valid;
  logic                s2_ok;
  logic [IDX_W-1:0]    s2_bar;
  entry_t              s2_entry;
  logic [15:0]         s2_weight;
  logic signed [16:0]  s2_diff;

  // stage 3: product
  logic                s3_valid;
  logic                s3_ok;
  logic [IDX_W-1:0]    s3_bar;
  entry_t              s3_entry;
  logic signed [33:0]  s3_prod;

  // handshake and flow
  logic out_free, s3_move, s2_move, s1_move, hazard, accept, wr_en;
  logic in_ok;

  assign out_free = !result_valid || !result_stall;
  assign s3_move  = !s3_valid || out_free;
  assign s2_move  = !s2_valid || s3_move;
  assign s1_move  = !s1_valid || s2_move;

  // a bar still being updated must finish before it is read again
  assign hazard = (s1_valid && s1_ok && (s1_bar == bar_index)) ||
                  (s2_valid && s2_ok && (s2_bar == bar_index)) ||
                  (s3_valid && s3_ok && (s3_bar == bar_index));

  assign item_stall = !s1_move || hazard;
  assign accept     = item_valid && !item_stall;
  assign in_ok      = {27'd0, bar_index} < 32'(BARS);
  assign wr_en      = s3_valid && s3_ok && s3_move;

  // stage 1 logic
  entry_t             s1_old;
  logic [15:0]        s1_weight;
  logic signed [16:0] s1_diff;

  always_comb begin
    s1_old    = rd_known ? rd_word : '0;
    s1_weight = (s1_level > s1_old.sm) ? attack_weight : release_weight;
    s1_diff   = $signed({1'b0, s1_level}) - $signed({1'b0, s1_old.sm});
  end

  // stage 3 logic: both directions reduce to old + floor(w*(lvl-old)/2^16)
  logic signed [17:0] s3_step;
  logic signed [17:0] s3_sum;
  logic [15:0]        new_sm;
  logic [15:0]        new_cap;
  logic [7:0]         new_hold;

  always_comb begin
    s3_step  = 18'(s3_prod >>> 16);
    s3_sum   = $signed({2'b00, s3_entry.sm}) + s3_step;
    new_sm   = s3_sum[15:0];
    new_cap  = s3_entry.cap;
    new_hold = s3_entry.hold;
    if (new_sm > s3_entry.cap) begin
      new_cap  = new_sm;
      new_hold = hold_length;
    end else if (s3_entry.hold != 8'd0) begin
      new_hold = s3_entry.hold - 8'd1;
    end else begin
      new_cap = (fall_step >= s3_entry.cap) ? 16'd0 : s3_entry.cap - fall_step;
    end
  end

  // memory: one read port at accept, one write port at writeback
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= mem[AW'(bar_index)];
    end
    if (wr_en) begin
      mem[AW'(s3_bar)] <= '{sm: new_sm, cap: new_cap, hold: new_hold};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known <= '0;
    end else if (wr_en) begin
      known[AW'(s3_bar)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_known <= known[AW'(bar_index)];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_move) s1_valid <= accept;
      if (s2_move) s2_valid <= s1_valid;
      if (s3_move) s3_valid <= s2_valid;
      if (out_free) result_valid <= s3_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s1_ok    <= in_ok;
      s1_bar   <= bar_index;
      s1_level <= level;
    end
    if (s2_move) begin
      s2_ok     <= s1_ok;
      s2_bar    <= s1_bar;
      s2_entry  <= s1_old;
      s2_weight <= s1_weight;
      s2_diff   <= s1_diff;
    end
    if (s3_move) begin
      s3_ok    <= s2_ok;
      s3_bar   <= s2_bar;
      s3_entry <= s2_entry;
      s3_prod  <= $signed({1'b0, s2_weight}) * s2_diff;
    end
    if (out_free) begin
      bar_number     <= s3_bar;
      smoothed_level <= s3_ok ? new_sm : '0;
      peak_cap       <= s3_ok ? new_cap : '0;
      hold_left      <= s3_ok ? new_hold : '0;
    end
  end

`ifndef SYNTHESIS
  // in-flight items never share a bar
  a_no_shared_bar: assert property (@(posedge clk) disable iff (rst)
    !((s1_valid && s1_ok && s2_valid && s2_ok && (s1_bar == s2_bar)) ||
      (s1_valid && s1_ok && s3_valid && s3_ok && (s1_bar == s3_bar)) ||
      (s2_valid && s2_ok && s3_valid && s3_ok && (s2_bar == s3_bar))))
    else $error("two in-flight items on one bar");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1_valid && (s1_bar == $past(bar_index))))
    else $error("accepted word did not enter stage 1");

  // a held cap was set by a nonzero smoothed level
  a_hold_has_cap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (hold_left != 8'd0)) |-> (peak_cap != 16'd0))
    else $error("hold running with zero cap");
`endif

endmodule

`default_nettype wire

/* dv/bar_smoother_with_peak_hold_core_test.sv */
// Testbench for the bar smoother core: directed and random bar levels checked against a local meter model.
module bar_smoother_with_peak_hold_core_test;
  import bshph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBARS       = BARS_DEFAULT;
  localparam int LATENCY     = 4;
  localparam int PARK_CYCLES = 200;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [IDX_W-1:0]   bar;
    logic [LEVEL_W-1:0] smooth;
    logic [LEVEL_W-1:0] cap;
    logic [HOLD_W-1:0]  hold;
  } bar_view_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  logic [IDX_W-1:0]   bar_index;
  logic [LEVEL_W-1:0] level;
  logic               result_valid;
  logic               result_stall;
  logic [IDX_W-1:0]   bar_number;
  logic [LEVEL_W-1:0] smoothed_level;
  logic [LEVEL_W-1:0] peak_cap;
  logic [HOLD_W-1:0]  hold_left;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  bar_smoother_with_peak_hold_core u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .bar_index      (bar_index),
    .level          (level),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .bar_number     (bar_number),
    .smoothed_level (smoothed_level),
    .peak_cap       (peak_cap),
    .hold_left      (hold_left),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // meter model state
  logic [LEVEL_W-1:0] bar_smooth [NBARS];
  logic [LEVEL_W-1:0] bar_cap    [NBARS];
  logic [HOLD_W-1:0]  bar_hold   [NBARS];
  logic [15:0]        attack_w;
  logic [15:0]        release_w;
  logic [7:0]         hold_frames;
  logic [15:0]        fall_amt;

  bar_view_t   due_bars [$];
  int          errors;
  int unsigned cycles;
  bit          park_req;
  bit          rx_quiet;
  bit          tx_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, due_bars.size());
      $display("bar_smoother_with_peak_hold_core_test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_meter();
    for (int i = 0; i < NBARS; i++) begin
      bar_smooth[i] = '0;
      bar_cap[i]    = '0;
      bar_hold[i]   = '0;
    end
    attack_w    = ATTACK_RESET;
    release_w   = RELEASE_RESET;
    hold_frames = HOLD_RESET;
    fall_amt    = FALL_RESET;
  endfunction

  function automatic void apply_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
    case (r)
      REG_ATTACK:  attack_w    = d;
      REG_RELEASE: release_w   = d;
      REG_HOLD:    hold_frames = d[7:0];
      REG_FALL:    fall_amt    = d;
      default: ;
    endcase
  endfunction

  // one frame of attack/release smoothing plus cap hold/fall for one bar
  function automatic bar_view_t advance_bar(input logic [IDX_W-1:0] b,
                                            input logic [LEVEL_W-1:0] lvl);
    bar_view_t          v;
    logic [LEVEL_W-1:0] old_sm;
    logic [LEVEL_W-1:0] sm;
    logic [LEVEL_W-1:0] cap;
    logic [HOLD_W-1:0]  hold;
    logic [32:0]        prod;
    old_sm = bar_smooth[b];
    cap    = bar_cap[b];
    hold   = bar_hold[b];
    if (lvl > old_sm) begin
      prod = 33'(attack_w) * 33'(lvl - old_sm);
      sm   = old_sm + prod[31:16];
    end else begin
      // falling step rounds toward minus infinity
      prod = 33'(release_w) * 33'(old_sm - lvl) + 33'd65535;
      sm   = (prod[32:16] > 17'(old_sm)) ? '0 : old_sm - prod[31:16];
    end
    if (sm > cap) begin
      cap  = sm;
      hold = hold_frames;
    end else if (hold > 0) begin
      hold = hold - 1'b1;
    end else begin
      cap = (fall_amt >= cap) ? '0 : cap - fall_amt;
    end
    bar_smooth[b] = sm;
    bar_cap[b]    = cap;
    bar_hold[b]   = hold;
    v.bar    = b;
    v.smooth = sm;
    v.cap    = cap;
    v.hold   = hold;
    return v;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (errors < PRINT_LIMIT)
      $display("mismatch on %s at cycle %0d: got %0d, want %0d", field, cycles, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    bar_view_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_bars.size() == 0) begin
        report_mismatch("unexpected word, bar", bar_number, -1);
      end else begin
        want = due_bars.pop_front();
        if (bar_number !== want.bar) report_mismatch("bar_number", bar_number, want.bar);
        if (smoothed_level !== want.smooth)
          report_mismatch("smoothed_level", smoothed_level, want.smooth);
        if (peak_cap !== want.cap) report_mismatch("peak_cap", peak_cap, want.cap);
        if (hold_left !== want.hold) report_mismatch("hold_left", hold_left, want.hold);
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long park on request
  initial begin
    int gap;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (park_req) begin
        park_req = 1'b0;
        result_stall <= 1'b1;
        repeat (PARK_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        @(posedge clk);
      end else if (rx_quiet) begin
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          result_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_bar(input logic [IDX_W-1:0] b, input logic [LEVEL_W-1:0] lvl);
    int gap;
    item_valid <= 1'b1;
    bar_index  <= b;
    level      <= lvl;
    do @(posedge clk); while (item_stall);
    due_bars.push_back(advance_bar(b, lvl));
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    item_valid <= 1'b0;
    while (due_bars.size() != 0) @(posedge clk);
  endtask

  // writes all four registers back to back; core must be idle
  task automatic write_regs(input logic [15:0] aw, input logic [15:0] rw,
                            input logic [7:0] hl, input logic [15:0] fs);
    cfg_reg_t         r;
    logic [CFG_W-1:0] d;
    wait_drain();
    r = REG_ATTACK;
    cfg_valid <= 1'b1;
    repeat (4) begin
      case (r)
        REG_ATTACK:  d = aw;
        REG_RELEASE: d = rw;
        REG_HOLD:    d = {8'd0, hl};
        default:     d = fs;
      endcase
      cfg_index <= r;
      cfg_data  <= d;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(r, d);
      r = r.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int n);
    int                 sel;
    logic [IDX_W-1:0]   b;
    logic [LEVEL_W-1:0] lvl;
    repeat (n) begin
      // a few hot bars so the same bar often follows itself in the pipe
      sel = $urandom_range(0, 9);
      b = (sel < 4) ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom_range(0, NBARS - 1));
      sel = $urandom_range(0, 9);
      if (sel == 0)      lvl = '0;
      else if (sel == 1) lvl = '1;
      else if (sel == 2) lvl = bar_smooth[b];
      else               lvl = LEVEL_W'($urandom);
      send_bar(b, lvl);
    end
  endtask

  task automatic test_reset_state();
    send_bar(5'd0, 16'd0);
    send_bar(5'd31, 16'hFFFF);
    send_bar(5'd31, 16'hFFFF);
    send_bar(5'd31, 16'd0);
    send_bar(5'd16, 16'd12345);
    send_bar(5'd16, bar_smooth[16]);
  endtask

  task automatic test_corner_settings();
    // max weights, zero hold, max fall: cap drops to zero on the first flat frame
    write_regs(16'hFFFF, 16'hFFFF, 8'd0, 16'hFFFF);
    send_bar(5'd5, 16'hFFFF);
    send_bar(5'd5, bar_smooth[5]);
    send_bar(5'd5, bar_smooth[5]);
    send_bar(5'd10, 16'h5555);
    send_bar(5'd10, 16'hAAAA);
    send_bar(5'd10, 16'd0);
    // longest hold, tiny release: floored falling steps
    write_regs(16'hFFFF, 16'd1, 8'hFF, 16'd0);
    send_bar(5'd7, 16'hFFFF);
    send_bar(5'd7, 16'd0);
    send_bar(5'd7, 16'd0);
    // zero weights and zero fall: smoothed levels and caps do not move
    write_regs(16'd0, 16'd0, 8'd0, 16'd0);
    send_bar(5'd21, 16'hFFFF);
    send_bar(5'd7, 16'd0);
    send_bar(5'd7, 16'hFFFF);
  endtask

  task automatic test_random_phases();
    write_regs(ATTACK_RESET, RELEASE_RESET, HOLD_RESET, FALL_RESET);
    send_random(100);
    write_regs(16'hFFFF, 16'hFFFF, 8'd0, 16'hFFFF);
    send_random(100);
    write_regs(16'd0, 16'd0, 8'hFF, 16'd0);
    send_random(60);
    write_regs(16'($urandom), 16'($urandom), 8'($urandom_range(0, 4)), 16'($urandom));
    send_random(100);
    // no idling on either side
    write_regs(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_random(100);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    write_regs(16'd32768, 16'hFFFF, 8'd1, 16'd1);
    send_random(100);
  endtask

  task automatic test_backpressure();
    write_regs(16'($urandom), 16'($urandom), 8'($urandom_range(0, 8)), 16'($urandom));
    park_req = 1'b1;
    tx_quiet = 1'b1;
    send_random(40);
    tx_quiet = 1'b0;
    wait_drain();
    send_random(20);
  endtask

  initial begin
    errors     = 0;
    cycles     = 0;
    park_req   = 1'b0;
    rx_quiet   = 1'b0;
    tx_quiet   = 1'b0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    bar_index  <= '0;
    level      <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ATTACK;
    cfg_data   <= '0;
    clear_meter();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_corner_settings();
    test_random_phases();
    test_backpressure();

    wait_drain();
    repeat (4 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("bar_smoother_with_peak_hold_core_test passed");
    end else begin
      $display("bar_smoother_with_peak_hold_core_test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bshph_pkg.sv
sv/bar_smoother_with_peak_hold_core.sv
dv/bar_smoother_with_peak_hold_core_test.sv
